[rtl/core/ufs_pkg.sv]
// Shared types and constants of the URL field splitter.
`default_nettype none
package ufs_pkg;

	localparam int MAX_URL_LEN = 256;
	localparam int MIN_URL_LEN = 4;
	// offset counter must reach MAX_URL_LEN + 1
	localparam int OFF_W = $clog2(MAX_URL_LEN + 2);

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [1:0] {
		PH_SCHEME = 2'd0,
		PH_AUTH   = 2'd1,
		PH_PATH   = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SHORT = 2'd1,
		ST_NOSEP = 2'd2,
		ST_LONG  = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [8:0]  scheme_end;
		logic        user_present;
		logic        pass_present;
		logic [8:0]  user_end;
		logic [8:0]  at_offset;
		logic [8:0]  host_end;
		logic [15:0] port_number;
		logic [8:0]  path_start;
		logic        path_present;
		logic [8:0]  query_start;
		logic [8:0]  hash_start;
	} out_item_t;

endpackage
`default_nettype wire

[rtl/core/ufs_parser.sv]
// Per-URL parse state and the single-byte update and result logic.
`default_nettype none
module ufs_parser (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              step,
	input  ufs_pkg::in_item_t item,
	output ufs_pkg::out_item_t res
);
	import ufs_pkg::*;

	typedef struct packed {
		logic [OFF_W-1:0] byte_offset;
		phase_t           phase;
		logic [1:0]       sep_match;
		logic [OFF_W-1:0] scheme_end;
		logic [OFF_W-1:0] first_colon;
		logic [OFF_W-1:0] last_at;
		logic [OFF_W-1:0] host_colon;
		logic [15:0]      port_accum;
		logic             digits_open;
		logic [OFF_W-1:0] path_start;
		logic [OFF_W-1:0] query_start;
		logic [OFF_W-1:0] hash_start;
	} parse_state_t;

	localparam logic [OFF_W-1:0] MAX_LEN_C = OFF_W'(MAX_URL_LEN);
	localparam logic [OFF_W-1:0] MIN_LEN_C = OFF_W'(MIN_URL_LEN);

	parse_state_t st_q;
	parse_state_t nxt;

	logic [7:0]       c;
	logic [OFF_W-1:0] off;
	logic [19:0]      port_sum;
	logic [OFF_W-1:0] len;
	logic [OFF_W-1:0] pstart;
	logic [OFF_W-1:0] fc_inc;
	logic             ucolon;
	logic             is_digit;

	assign c        = item.char_byte;
	assign off      = st_q.byte_offset;
	assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
	// acc * 10 + digit as two shifts and adds
	assign port_sum = {1'b0, st_q.port_accum, 3'b000} + {3'b000, st_q.port_accum, 1'b0}
		+ {12'd0, c - CH_ZERO};

	always_comb begin
		nxt = st_q;
		if (off < MAX_LEN_C) begin
			unique case (st_q.phase)
				PH_SCHEME: begin
					if (st_q.sep_match == 2'd2 && c == CH_SLASH) begin
						nxt.scheme_end = off - OFF_W'(2);
						nxt.phase      = PH_AUTH;
						nxt.sep_match  = 2'd0;
					end else if (st_q.sep_match == 2'd1 && c == CH_SLASH) begin
						nxt.sep_match = 2'd2;
					end else begin
						nxt.sep_match = (c == CH_COLON) ? 2'd1 : 2'd0;
					end
				end
				PH_AUTH: begin
					priority if (c == CH_SLASH) begin
						nxt.path_start = off;
						nxt.phase      = PH_PATH;
					end else if (c == CH_AT) begin
						nxt.last_at     = off;
						nxt.host_colon  = '0;
						nxt.port_accum  = '0;
						nxt.digits_open = 1'b0;
					end else if (c == CH_COLON) begin
						if (st_q.first_colon == '0) nxt.first_colon = off;
						if (st_q.host_colon == '0) begin
							nxt.host_colon  = off;
							nxt.port_accum  = '0;
							nxt.digits_open = 1'b1;
						end else begin
							nxt.digits_open = 1'b0;
						end
					end else if (is_digit && st_q.digits_open) begin
						nxt.port_accum = (port_sum > 20'd65535) ? 16'hFFFF : port_sum[15:0];
					end else begin
						nxt.digits_open = 1'b0;
					end
				end
				PH_PATH: begin
					if (c == CH_QUEST && st_q.query_start == '0)
						nxt.query_start = off + OFF_W'(1);
					if (c == CH_HASH && st_q.hash_start == '0)
						nxt.hash_start = off + OFF_W'(1);
				end
				default: begin
					nxt.phase = st_q.phase;
				end
			endcase
		end
		// keep counting past the limit so long URLs are flagged
		if (off <= MAX_LEN_C) nxt.byte_offset = off + OFF_W'(1);
	end

	assign len    = nxt.byte_offset;
	assign pstart = (nxt.path_start != '0) ? nxt.path_start : len;
	assign fc_inc = nxt.first_colon + OFF_W'(1);
	assign ucolon = (nxt.first_colon != '0) && (nxt.first_colon < nxt.last_at);

	always_comb begin
		res = '0;
		priority if (len < MIN_LEN_C) begin
			res.status = ST_SHORT;
		end else if (len > MAX_LEN_C) begin
			res.status = ST_LONG;
		end else if (nxt.phase == PH_SCHEME) begin
			res.status = ST_NOSEP;
		end else begin
			res.status     = ST_OK;
			res.scheme_end = 9'(nxt.scheme_end);
			if (nxt.last_at != '0) begin
				res.user_present = 1'b1;
				res.pass_present = ucolon && (fc_inc != nxt.last_at);
				res.user_end     = ucolon ? 9'(nxt.first_colon) : 9'(nxt.last_at);
				res.at_offset    = 9'(nxt.last_at);
			end
			res.host_end     = (nxt.host_colon != '0) ? 9'(nxt.host_colon) : 9'(pstart);
			res.port_number  = nxt.port_accum;
			res.path_start   = 9'(pstart);
			res.path_present = (nxt.path_start != '0);
			res.query_start  = 9'(nxt.query_start);
			res.hash_start   = 9'(nxt.hash_start);
		end
	end

	// clear everything once the URL closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (step) begin
			st_q <= item.last_byte ? parse_state_t'('0) : nxt;
		end
	end

endmodule
`default_nettype wire

[rtl/core/ufs_result_reg.sv]
// Single-entry result register on the output channel.
`default_nettype none
module ufs_result_reg (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                load,
	input  ufs_pkg::out_item_t load_data,
	output logic               space,
	output logic               valid,
	input  wire                ready,
	output ufs_pkg::out_item_t data
);
	import ufs_pkg::*;

	logic valid_q;

	assign space = !valid_q || ready;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) data <= load_data;
	end

endmodule
`default_nettype wire

[rtl/core/url_field_splitter_unit.sv]
// URL field splitter: byte stream in, one set of part offsets per URL out.
//
// Usage: send the URL one byte per transfer on byte_valid/byte_ready/byte_data,
// with last_byte set on the final byte. That final byte produces one transfer
// on result_valid/result_ready/result_data carrying the status and the offsets
// of scheme, user info, host, port, path, query and hash; other bytes produce
// nothing. The next URL may follow directly.
// Throughput: one byte per cycle while no final byte is held, set by the single update
// pass that sits between the input register and the parse state / result register.
// Order: a byte enters the input register at its transfer and is parsed from there;
// on a final byte the result register then loads and offers the result.
// Stall: while the result register is full and not being taken, a final byte
// waits in the input register and byte_ready drops; other bytes keep flowing.
// Reset: arst_n clears the parse state and both valid flags; the first byte
// after reset starts a new URL.
`default_nettype none
module url_field_splitter_unit (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                byte_valid,
	output logic               byte_ready,
	input  ufs_pkg::in_item_t  byte_data,
	output logic               result_valid,
	input  wire                result_ready,
	output ufs_pkg::out_item_t result_data
);
	import ufs_pkg::*;

	in_item_t  item_s1;
	logic      valid_s1;
	logic      advance;
	logic      load_res;
	logic      res_space;
	out_item_t res;

	assign advance    = valid_s1 && (!item_s1.last_byte || res_space);
	assign load_res   = advance && item_s1.last_byte;
	assign byte_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && byte_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) item_s1 <= byte_data;
	end

	ufs_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.res    (res)
	);

	ufs_result_reg u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load_res),
		.load_data (res),
		.space     (res_space),
		.valid     (result_valid),
		.ready     (result_ready),
		.data      (result_data)
	);

	// never overwrite a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_res |-> (!result_valid || result_ready))
		else $error("result register overwritten");

	// input stalls only behind a held final byte
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_ready |-> (valid_s1 && item_s1.last_byte && result_valid && !result_ready))
		else $error("input stalled without cause");

	// a failed URL carries no offsets
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_data.status != ST_OK) |->
		(result_data.path_start == '0 && result_data.port_number == '0
		&& result_data.scheme_end == '0 && result_data.user_present == 1'b0))
		else $error("failed result has nonzero fields");

endmodule
`default_nettype wire
